[src/brcs_pkg.sv]
package brcs_pkg;

  // default coordinate width in bits
  localparam int COORD_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [1:0] REG_WIN_X = 2'd0;
  localparam logic [1:0] REG_WIN_Y = 2'd1;
  localparam logic [1:0] REG_WIN_W = 2'd2;
  localparam logic [1:0] REG_WIN_H = 2'd3;

endpackage

[src/brcs_rdiv.sv]
module brcs_rdiv import brcs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SIDE_BITS  = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic signed [2*COORD_BITS+2:0] num,
  input  logic [COORD_BITS-1:0]       den,
  input  logic [SIDE_BITS-1:0]        side_in,
  output logic                        out_vld,
  output logic signed [COORD_BITS+3:0] quo,
  output logic [SIDE_BITS-1:0]        side_out
);

  // round(num / den) half away from zero as floor((2|num| + den) / (2 den)),
  // one quotient bit per stage
  localparam int C  = COORD_BITS;
  localparam int QB = C + 3;
  localparam int NW = 2 * C + 3;
  localparam int DW = NW + 1;
  localparam int RW = C + 1;

  logic [NW-1:0] mag;
  logic [DW-1:0] dividend;

  assign mag      = num[NW-1] ? NW'(-num) : NW'(num);
  assign dividend = {mag, 1'b0} + DW'(den);

  logic                 vld  [QB+1];
  logic [RW-1:0]        rem  [QB+1];
  logic [QB-1:0]        low  [QB+1];
  logic [RW-1:0]        dvs  [QB+1];
  logic [QB-1:0]        q    [QB+1];
  logic                 neg  [QB+1];
  logic [SIDE_BITS-1:0] side [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
    if (en) begin
      rem[0]  <= dividend[DW-1:QB];
      low[0]  <= dividend[QB-1:0];
      dvs[0]  <= {den, 1'b0};
      q[0]    <= '0;
      neg[0]  <= num[NW-1];
      side[0] <= side_in;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [RW:0]   t;
    logic          ge;
    logic [RW-1:0] t_sub;

    assign t     = {rem[i], low[i][QB-1]};
    assign ge    = t >= {1'b0, dvs[i]};
    assign t_sub = RW'(t - {1'b0, dvs[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rem[i+1]  <= ge ? t_sub : RW'(t);
        low[i+1]  <= {low[i][QB-2:0], 1'b0};
        dvs[i+1]  <= dvs[i];
        q[i+1]    <= {q[i][QB-2:0], ge};
        neg[i+1]  <= neg[i];
        side[i+1] <= side[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[QB];
    end
    if (en) begin
      quo      <= neg[QB] ? -$signed({1'b0, q[QB]}) : $signed({1'b0, q[QB]});
      side_out <= side[QB];
    end
  end

endmodule

[src/blit_rect_clip_and_scale.sv]
// throughput: one request per cycle while the output is not stalled; two rounding dividers
//   in series per axis, each one quotient bit per stage, set the depth
// a stall on the output holds the whole pipeline in place
// reset (synchronous): clears all valid bits and the window registers
module blit_rect_clip_and_scale import brcs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // src_left, src_top, src_right, src_bottom, dst_left, dst_top, dst_right, dst_bottom
  input  logic [8*COORD_BITS-1:0] s_axis_tdata,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // out_src_left, out_src_top, out_src_right, out_src_bottom,
  // out_dst_left, out_dst_top, out_dst_right, out_dst_bottom, zero pad
  output logic [((8*COORD_BITS-4+7)/8)*8-1:0] m_axis_tdata,
  // hit
  output logic [0:0]              m_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int C     = COORD_BITS;
  localparam int NW    = 2 * C + 3;
  localparam int QW    = C + 4;
  localparam int OUT_W = ((8 * C - 4 + 7) / 8) * 8;

  localparam logic signed [QW-1:0] SAT_HI = {{5{1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [QW-1:0] SAT_LO = {{5{1'b1}}, {(C-1){1'b0}}};

  // carried alongside the first division of an axis
  typedef struct packed {
    logic [C-1:0]        sw;
    logic signed [C:0]   dw;
    logic [C-1:0]        cw;
    logic                miss;
    logic [C-2:0]        l1;
    logic [C-2:0]        l2;
  } side1_t;

  // carried alongside the second division of an axis
  typedef struct packed {
    logic signed [QW-1:0] n1;
    logic                 miss;
    logic [C-2:0]         l1;
    logic [C-2:0]         l2;
  } side2_t;

  function automatic logic signed [C-1:0] sat(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return C'(r);
  endfunction

  // window registers, index 0 is x, 1 is y
  logic signed [C-1:0] win_pos [2];
  logic [C-2:0]        win_len [2];

  logic en;
  logic a_vld, b_vld, c_vld, d_vld, e_vld;

  logic                o_vld;
  logic                o_hit;
  logic [OUT_W-1:0]    o_data;

  // per-axis results at the end of the second divider
  logic                ax_vld  [2];
  logic                ax_miss [2];
  logic [C-2:0]        ax_l1   [2];
  logic [C-2:0]        ax_l2   [2];
  logic signed [C-1:0] ax_n1   [2];
  logic signed [C-1:0] ax_n2   [2];

  // whole pipeline moves unless a result is waiting
  assign en            = !o_vld || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = o_vld;
  assign m_axis_tdata  = o_data;
  assign m_axis_tuser  = o_hit;
  assign pready        = 1'b1;

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      win_pos[0] <= '0;
      win_pos[1] <= '0;
      win_len[0] <= '0;
      win_len[1] <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_WIN_X: win_pos[0] <= pwdata[C-1:0];
        REG_WIN_Y: win_pos[1] <= pwdata[C-1:0];
        REG_WIN_W: win_len[0] <= pwdata[C-2:0];
        REG_WIN_H: win_len[1] <= pwdata[C-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIN_X: prdata = 32'({win_pos[0]} & {C{1'b1}});
      REG_WIN_Y: prdata = 32'({win_pos[1]} & {C{1'b1}});
      REG_WIN_W: prdata = 32'(win_len[0]);
      REG_WIN_H: prdata = 32'(win_len[1]);
      default:   prdata = '0;
    endcase
  end

  // shared valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s_axis_tvalid;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
    end
  end

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    logic signed [C-1:0] in_s1, in_s2, in_d1, in_d2;

    assign in_s1 = s_axis_tdata[ax*C +: C];
    assign in_s2 = s_axis_tdata[(2+ax)*C +: C];
    assign in_d1 = s_axis_tdata[(4+ax)*C +: C];
    assign in_d2 = s_axis_tdata[(6+ax)*C +: C];

    // stage a: source size, window end, destination size
    logic signed [C:0]   a_sw, a_wend, a_dw;
    logic signed [C-1:0] a_s1, a_s2, a_d1;
    // stage b: overlap test and clip corners
    logic                b_miss;
    logic signed [C-1:0] b_c1, b_s1, b_d1;
    logic signed [C:0]   b_c2, b_sw, b_dw;
    // stage c: trim offset, clipped size, window-local corners
    logic                c_miss;
    logic [C-1:0]        c_off, c_cw, c_sw;
    logic [C-2:0]        c_l1, c_l2;
    logic signed [C:0]   c_dw;
    logic signed [C-1:0] c_d1;
    // stage d: products of the first corner
    logic signed [2*C+1:0] d_pa, d_pb;
    side1_t              d_side;
    // stage e: numerator of the first corner
    logic signed [NW-1:0] e_num;
    side1_t              e_side;

    always_ff @(posedge clk) begin
      if (en) begin
        a_sw   <= (C+1)'(in_s2) - (C+1)'(in_s1);
        a_wend <= (C+1)'(win_pos[ax]) + (C+1)'({1'b0, win_len[ax]});
        a_dw   <= (C+1)'(in_d2) - (C+1)'(in_d1);
        a_s1   <= in_s1;
        a_s2   <= in_s2;
        a_d1   <= in_d1;

        b_miss <= (a_sw <= 0) || (a_s2 <= win_pos[ax]) || ((C+1)'(a_s1) >= a_wend);
        b_c1   <= (a_s1 > win_pos[ax]) ? a_s1 : win_pos[ax];
        b_c2   <= ((C+1)'(a_s2) < a_wend) ? (C+1)'(a_s2) : a_wend;
        b_s1   <= a_s1;
        b_d1   <= a_d1;
        b_sw   <= a_sw;
        b_dw   <= a_dw;

        c_miss <= b_miss;
        c_off  <= C'((C+1)'(b_c1) - (C+1)'(b_s1));
        c_cw   <= C'(b_c2 - (C+1)'(b_c1));
        c_sw   <= C'(b_sw);
        c_l1   <= (C-1)'(b_c1 - win_pos[ax]);
        c_l2   <= (C-1)'(b_c2 - (C+1)'(win_pos[ax]));
        c_dw   <= b_dw;
        c_d1   <= b_d1;

        d_pa        <= c_d1 * $signed({1'b0, c_sw});
        d_pb        <= c_dw * $signed({1'b0, c_off});
        d_side.sw   <= c_sw;
        d_side.dw   <= c_dw;
        d_side.cw   <= c_cw;
        d_side.miss <= c_miss;
        d_side.l1   <= c_l1;
        d_side.l2   <= c_l2;

        e_num  <= NW'(d_pa) + NW'(d_pb);
        e_side <= d_side;
      end
    end

    // first corner: round((d1*sw + dw*off) / sw)
    logic                 dv1_vld;
    logic signed [QW-1:0] dv1_q;
    logic [$bits(side1_t)-1:0] dv1_side_vec;
    side1_t               dv1_side;

    brcs_rdiv #(
      .COORD_BITS (C),
      .SIDE_BITS  ($bits(side1_t))
    ) u_div1 (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_vld   (e_vld),
      .num      (e_num),
      .den      (e_side.sw),
      .side_in  (e_side),
      .out_vld  (dv1_vld),
      .quo      (dv1_q),
      .side_out (dv1_side_vec)
    );

    assign dv1_side = dv1_side_vec;

    // stage f: products of the second corner, from the rounded first corner
    logic                  f_vld, g_vld;
    logic signed [2*C+4:0] f_pa;
    logic signed [2*C+1:0] f_pb;
    logic [C-1:0]          f_sw, g_sw;
    side2_t                f_side, g_side;
    logic signed [NW-1:0]  g_num;

    always_ff @(posedge clk) begin
      if (rst) begin
        f_vld <= 1'b0;
        g_vld <= 1'b0;
      end else if (en) begin
        f_vld <= dv1_vld;
        g_vld <= f_vld;
      end
      if (en) begin
        f_pa        <= dv1_q * $signed({1'b0, dv1_side.sw});
        f_pb        <= dv1_side.dw * $signed({1'b0, dv1_side.cw});
        f_sw        <= dv1_side.sw;
        f_side.n1   <= dv1_q;
        f_side.miss <= dv1_side.miss;
        f_side.l1   <= dv1_side.l1;
        f_side.l2   <= dv1_side.l2;

        g_num  <= NW'(f_pa) + NW'(f_pb);
        g_sw   <= f_sw;
        g_side <= f_side;
      end
    end

    // second corner: round((n1*sw + dw*cw) / sw)
    logic                 dv2_vld;
    logic signed [QW-1:0] dv2_q;
    logic [$bits(side2_t)-1:0] dv2_side_vec;
    side2_t               dv2_side;

    brcs_rdiv #(
      .COORD_BITS (C),
      .SIDE_BITS  ($bits(side2_t))
    ) u_div2 (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_vld   (g_vld),
      .num      (g_num),
      .den      (g_sw),
      .side_in  (g_side),
      .out_vld  (dv2_vld),
      .quo      (dv2_q),
      .side_out (dv2_side_vec)
    );

    assign dv2_side = dv2_side_vec;

    assign ax_vld[ax]  = dv2_vld;
    assign ax_miss[ax] = dv2_side.miss;
    assign ax_l1[ax]   = dv2_side.l1;
    assign ax_l2[ax]   = dv2_side.l2;
    assign ax_n1[ax]   = sat(dv2_side.n1);
    assign ax_n2[ax]   = sat(dv2_q);
  end

  // output register: a miss zeroes every coordinate
  logic             miss_any;
  logic [OUT_W-1:0] res_data;

  assign miss_any = ax_miss[0] || ax_miss[1];

  always_comb begin
    res_data = '0;
    if (!miss_any) begin
      res_data[0*(C-1) +: C-1]   = ax_l1[0];
      res_data[1*(C-1) +: C-1]   = ax_l1[1];
      res_data[2*(C-1) +: C-1]   = ax_l2[0];
      res_data[3*(C-1) +: C-1]   = ax_l2[1];
      res_data[4*(C-1) +: C]     = ax_n1[0];
      res_data[4*(C-1)+C +: C]   = ax_n1[1];
      res_data[4*(C-1)+2*C +: C] = ax_n2[0];
      res_data[4*(C-1)+3*C +: C] = ax_n2[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= ax_vld[0] && ax_vld[1];
    end
    if (en) begin
      o_hit  <= !miss_any;
      o_data <= res_data;
    end
  end

endmodule

[verif/blit_checker.sv]
`timescale 1ns / 100ps

module blit_checker import brcs_pkg::*; #(
  parameter int CB = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [8*CB-1:0]               s_axis_tdata,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [((8*CB-4+7)/8)*8-1:0]   m_axis_tdata,
  input  logic [0:0]                    m_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  output int                            errors,
  output int                            pending
);

  localparam int OW = ((8*CB-4+7)/8)*8;

  typedef struct packed {
    logic          hit;
    logic [OW-1:0] coords;
  } clip_result_t;

  longint win_x, win_y, win_w, win_h;
  clip_result_t blit_results_q[$];

  function automatic longint sx(logic [8*CB-1:0] d, int i);
    logic [CB-1:0] v;
    v = d[i*CB +: CB];
    return longint'($signed(v));
  endfunction

  // exact rounding half away from zero, den > 0
  function automatic longint rdiv(longint num, longint den);
    longint m;
    longint q;
    m = (num < 0) ? -num : num;
    q = (2*m + den) / (2*den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [CB-1:0] sat(longint v);
    longint hi;
    hi = (longint'(1) << (CB-1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi-1) v = -hi-1;
    return v[CB-1:0];
  endfunction

  function automatic clip_result_t clip_blit(logic [8*CB-1:0] d);
    clip_result_t r;
    longint s1x, s1y, s2x, s2y, d1x, d1y, d2x, d2y, sw, sh, wx2, wy2;
    longint c1x, c1y, c2x, c2y, n1x, n2x, n1y, n2y;
    s1x = sx(d,0); s1y = sx(d,1); s2x = sx(d,2); s2y = sx(d,3);
    d1x = sx(d,4); d1y = sx(d,5); d2x = sx(d,6); d2y = sx(d,7);
    sw = s2x - s1x; sh = s2y - s1y;
    wx2 = win_x + win_w; wy2 = win_y + win_h;
    r = '0;
    if (sw <= 0 || sh <= 0 || s2x <= win_x || s1x >= wx2 || s2y <= win_y || s1y >= wy2)
      return r;
    c1x = (s1x > win_x) ? s1x : win_x;
    c1y = (s1y > win_y) ? s1y : win_y;
    c2x = (s2x < wx2) ? s2x : wx2;
    c2y = (s2y < wy2) ? s2y : wy2;
    // products stay well within 64 bits at 16-bit coordinates
    n1x = rdiv(d1x*sw + (d2x-d1x)*(c1x-s1x), sw);
    n2x = rdiv(n1x*sw + (d2x-d1x)*(c2x-c1x), sw);
    n1y = rdiv(d1y*sh + (d2y-d1y)*(c1y-s1y), sh);
    n2y = rdiv(n1y*sh + (d2y-d1y)*(c2y-c1y), sh);
    r.hit = 1'b1;
    r.coords[0*(CB-1) +: CB-1] = (CB-1)'(c1x - win_x);
    r.coords[1*(CB-1) +: CB-1] = (CB-1)'(c1y - win_y);
    r.coords[2*(CB-1) +: CB-1] = (CB-1)'(c2x - win_x);
    r.coords[3*(CB-1) +: CB-1] = (CB-1)'(c2y - win_y);
    r.coords[4*(CB-1) + 0*CB +: CB] = sat(n1x);
    r.coords[4*(CB-1) + 1*CB +: CB] = sat(n1y);
    r.coords[4*(CB-1) + 2*CB +: CB] = sat(n2x);
    r.coords[4*(CB-1) + 3*CB +: CB] = sat(n2y);
    return r;
  endfunction

  assign pending = blit_results_q.size();

  always @(posedge clk) begin
    clip_result_t exp_r;
    if (rst) begin
      win_x = 0; win_y = 0; win_w = 0; win_h = 0;
      errors = 0;
      blit_results_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_WIN_X: win_x = longint'($signed(pwdata[CB-1:0]));
          REG_WIN_Y: win_y = longint'($signed(pwdata[CB-1:0]));
          REG_WIN_W: win_w = longint'(pwdata[CB-2:0]);
          REG_WIN_H: win_h = longint'(pwdata[CB-2:0]);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        blit_results_q.push_back(clip_blit(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (blit_results_q.size() == 0) begin
          $display("%t unexpected result hit=%0d data=%h", $time, m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          exp_r = blit_results_q.pop_front();
          if (exp_r.hit !== m_axis_tuser[0]) begin
            $display("%t hit mismatch: expected %0d actual %0d", $time, exp_r.hit,
                     m_axis_tuser[0]);
            errors++;
          end
          if (exp_r.coords !== m_axis_tdata) begin
            $display("%t coords mismatch: expected %h actual %h", $time, exp_r.coords,
                     m_axis_tdata);
            errors++;
          end
        end
      end
    end
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb import brcs_pkg::*; ();

  localparam int CB = COORD_BITS_DEF;
  localparam int OW = ((8*CB-4+7)/8)*8;
  localparam int LATENCY = 2*CB + 18;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk, rst;
  logic [8*CB-1:0] s_axis_tdata;   // src_left .. dst_bottom, src_left lowest
  logic s_axis_tvalid, s_axis_tready;
  logic [OW-1:0] m_axis_tdata;     // out_src_left .. out_dst_bottom, zero pad
  logic [0:0] m_axis_tuser;        // hit
  logic m_axis_tvalid, m_axis_tready;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  int errors, pending;

  // idling: at random with a probability of about 9 percent, none while calm is set
  bit calm;
  int idle_cycles;

  blit_rect_clip_and_scale DUT (.*);

  blit_checker #(.CB(CB)) chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver side stalls at random
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm || ($urandom_range(99) >= 9);
  end

  // watchdog counts cycles with no accepted request on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // setup then access; the bus is released by the caller
  task automatic reg_write(int idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 4'(idx*4); pwdata <= val; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic set_window(int wx, int wy, int ww, int wh);
    reg_write(REG_WIN_X, wx);
    reg_write(REG_WIN_Y, wy);
    reg_write(REG_WIN_W, ww);
    reg_write(REG_WIN_H, wh);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // drains all outstanding results, then lets the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // one blit request; holds valid until accepted, the next call or drain drops it
  task automatic send_blit(int sl, int st, int sr, int sb, int dl, int dt, int dr, int db);
    while (!calm && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata <= {db[CB-1:0], dr[CB-1:0], dt[CB-1:0], dl[CB-1:0],
                     sb[CB-1:0], sr[CB-1:0], st[CB-1:0], sl[CB-1:0]};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic int rc();
    case ($urandom_range(5))
      0: return $urandom_range(65535) - 32768;
      1: return ($urandom_range(1)) ? 32767 - $urandom_range(40) : -32768 + $urandom_range(40);
      default: return $urandom_range(400) - 200;
    endcase
  endfunction

  // mostly well-formed source rectangles near the window, some noise
  task automatic random_blit();
    int sl, st, sw, sh;
    if ($urandom_range(9) == 0) begin
      send_blit(rc(), rc(), rc(), rc(), rc(), rc(), rc(), rc());
    end else begin
      sl = $urandom_range(400) - 200; st = $urandom_range(400) - 200;
      sw = $urandom_range(300); sh = $urandom_range(300);
      send_blit(sl, st, sl + sw, st + sh, rc(), rc(), rc(), rc());
    end
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window is zero-size at origin: straddling source hits with zero size
    send_blit(-5, -5, 5, 5, 0, 0, 100, 100);
    send_blit(0, 0, 10, 10, 0, 0, 100, 100);
    drain();

    set_window(10, 20, 100, 50);
    send_blit(0, 0, 200, 200, 0, 0, 1000, 1000);         // source covers window
    send_blit(30, 30, 40, 40, -100, -100, 100, 100);     // source inside
    send_blit(0, 0, 7, 9, 500, 500, 0, 0);               // inverted destination
    send_blit(5, 25, 15, 35, 0, 0, 3, 3);                // odd ratios, halves
    send_blit(50, 50, 50, 60, 0, 0, 10, 10);             // zero width
    send_blit(60, 50, 50, 60, 0, 0, 10, 10);             // negative width
    send_blit(50, 60, 60, 50, 0, 0, 10, 10);             // negative height
    send_blit(-100, 0, 10, 100, 0, 0, 10, 10);           // touches left edge: miss
    send_blit(110, 30, 200, 40, 0, 0, 10, 10);           // right edge: miss
    send_blit(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
    send_blit(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768);
    send_blit(11, 21, 12, 22, -32768, -32768, 32767, 32767); // one-pixel source, full-range destination
    drain();

    // extreme window settings
    set_window(-32768, -32768, 32767, 32767);
    send_blit(-32768, -32768, 32767, 32767, -32768, 0, 32767, 1);
    send_blit(-1, -1, 1, 1, 32767, -32768, -32768, 32767);
    drain();
    set_window(32767, 32767, 32767, 32767);
    send_blit(32700, 32700, 32767, 32767, 0, 0, 9, 9);
    send_blit(32766, 32766, 32767, 32767, 0, 0, 9, 9);
    drain();

    // random phases over several windows, one stretch without idling
    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 2);
      case (ph)
        0: set_window(-50, -50, 100, 100);
        1: set_window(0, 0, 0, 0);
        3: set_window(-32768, -32768, 32767, 32767);
        default: set_window($urandom_range(200) - 100, $urandom_range(200) - 100,
                            $urandom_range(300), $urandom_range(300));
      endcase
      for (int i = 0; i < 150; i++) random_blit();
      drain();
    end

    if (errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

[filelist.f]
src/brcs_pkg.sv
src/brcs_rdiv.sv
src/blit_rect_clip_and_scale.sv
verif/blit_checker.sv
verif/tb.sv
